// ----- rtl/smcp_pkg.sv -----
// Package for the serial motor command decoder with PWM.
// Holds the response and direction codes, character codes and the byte class type.
// No dependencies.
package smcp_pkg;

    localparam int unsigned DUTY_W   = 7;
    localparam int unsigned VALUE_W  = 10;
    localparam logic [DUTY_W-1:0]  DUTY_MAX  = 7'd100;
    localparam logic [VALUE_W-1:0] VALUE_SAT = 10'd101;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_L  = 8'h75;
    localparam logic [7:0] CH_UP_U  = 8'h55;
    localparam logic [7:0] CH_DN_L  = 8'h64;
    localparam logic [7:0] CH_DN_U  = 8'h44;
    localparam logic [7:0] CH_ST_L  = 8'h73;
    localparam logic [7:0] CH_ST_U  = 8'h53;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        RSP_NONE     = 3'd0,
        RSP_UP       = 3'd1,
        RSP_DOWN     = 3'd2,
        RSP_STOP     = 3'd3,
        RSP_DUTY     = 3'd4,
        RSP_ERROR    = 3'd5,
        RSP_OVERFLOW = 3'd6
    } t_rsp;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef struct packed {
        logic       is_up;
        logic       is_down;
        logic       is_stop;
        logic       is_eol;
        logic       is_digit;
        logic [3:0] digit;
    } t_byte_class;

endpackage

// ----- rtl/smcp_if.sv -----
// Handshake interfaces for the command word input and the result word output.
// Depends on smcp_pkg for the result field types.
interface smcp_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface smcp_out_if;
    logic                           valid;
    logic                           ready;
    smcp_pkg::t_rsp                 response;
    logic [smcp_pkg::DUTY_W-1:0]    duty_percent;
    logic                           regulator_enable;
    logic                           drive_up;
    logic                           drive_down;
    logic                           pwm_level;

    modport source (output valid, output response, output duty_percent,
                    output regulator_enable, output drive_up, output drive_down,
                    output pwm_level, input ready);
    modport sink (input valid, input response, input duty_percent,
                  input regulator_enable, input drive_up, input drive_down,
                  input pwm_level, output ready);
endinterface

// ----- rtl/serial_motor_command_pwm_top.sv -----
// Each accepted word's result is registered in the output register.
// Throughput: one word per cycle, sustained while the result side takes each word; the
// single output register lets a new word in during the cycle its predecessor is taken.
// Reset (synchronous, active low) clears the line state, duty, phase, direction, PWM level and output valid.
// Top level of the serial motor command decoder with PWM; depends on smcp_pkg, smcp_if
// and smcp_decode.
module serial_motor_command_pwm_top #(
    parameter int unsigned LINE_BUFFER_SIZE = 8,
    parameter int unsigned PWM_PERIOD_TICKS = 100
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smcp_in_if.sink    i_cmd,
    smcp_out_if.source o_rsp
);
    import smcp_pkg::*;

    localparam int unsigned CNT_W = $clog2(LINE_BUFFER_SIZE);
    localparam int unsigned PH_W  = $clog2(PWM_PERIOD_TICKS);
    localparam int unsigned CMP_W = (PH_W > DUTY_W) ? PH_W : DUTY_W;
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(LINE_BUFFER_SIZE - 1);
    localparam logic [PH_W-1:0]  PHASE_TOP = PH_W'(PWM_PERIOD_TICKS - 1);

    t_byte_class w_class;

    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_digits, n_digits;
    logic [DUTY_W-1:0]  r_value, n_value;
    logic [DUTY_W-1:0]  r_duty, n_duty;
    logic [PH_W-1:0]    r_phase, n_phase;
    t_dir               r_dir, n_dir;
    logic               r_pwm, n_pwm;
    t_rsp               n_rsp;

    logic               r_out_valid;
    t_rsp               r_rsp;
    logic [DUTY_W-1:0]  r_out_duty;
    logic               r_out_en, r_out_up, r_out_down, r_out_pwm;

    logic               w_accept;
    logic [VALUE_W-1:0] w_prod;

    smcp_decode u_decode (
        .i_byte  (i_cmd.rx_byte),
        .o_class (w_class)
    );

    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_prod      = {r_value, 3'b000} + {2'b00, r_value, 1'b0} + VALUE_W'(w_class.digit);

    always_comb begin
        n_count  = r_count;
        n_digits = r_digits;
        n_value  = r_value;
        n_duty   = r_duty;
        n_phase  = r_phase;
        n_dir    = r_dir;
        n_pwm    = r_pwm;
        n_rsp    = RSP_NONE;
        if (i_cmd.mode) begin
            n_phase = (r_phase == PHASE_TOP) ? '0 : r_phase + 1'b1;
            n_pwm   = CMP_W'(n_phase) < CMP_W'(r_duty);
        end else if (w_class.is_up || w_class.is_down || w_class.is_stop) begin
            n_count  = '0;
            n_digits = 1'b1;
            n_value  = '0;
            priority if (w_class.is_up) begin
                n_dir = DIR_UP;
                n_rsp = RSP_UP;
            end else if (w_class.is_down) begin
                n_dir = DIR_DOWN;
                n_rsp = RSP_DOWN;
            end else begin
                n_dir = DIR_STOP;
                n_rsp = RSP_STOP;
            end
        end else if (w_class.is_eol) begin
            if (r_count != '0) begin
                if (r_digits) begin
                    n_duty = (r_value > DUTY_MAX) ? DUTY_MAX : r_value;
                    n_rsp  = RSP_DUTY;
                end else begin
                    n_rsp = RSP_ERROR;
                end
                n_count  = '0;
                n_digits = 1'b1;
                n_value  = '0;
            end
        end else if (r_count < CNT_LAST) begin
            n_count = r_count + 1'b1;
            if (w_class.is_digit) begin
                n_value = (w_prod > VALUE_SAT) ? VALUE_SAT[DUTY_W-1:0] : w_prod[DUTY_W-1:0];
            end else begin
                n_digits = 1'b0;
            end
        end else begin
            n_count  = '0;
            n_digits = 1'b1;
            n_value  = '0;
            n_rsp    = RSP_OVERFLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_digits    <= 1'b1;
            r_value     <= '0;
            r_duty      <= '0;
            r_phase     <= '0;
            r_dir       <= DIR_STOP;
            r_pwm       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count  <= n_count;
                r_digits <= n_digits;
                r_value  <= n_value;
                r_duty   <= n_duty;
                r_phase  <= n_phase;
                r_dir    <= n_dir;
                r_pwm    <= n_pwm;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp      <= n_rsp;
            r_out_duty <= n_duty;
            r_out_en   <= (n_dir != DIR_STOP);
            r_out_up   <= (n_dir == DIR_UP);
            r_out_down <= (n_dir == DIR_DOWN);
            r_out_pwm  <= n_pwm;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.response         = r_rsp;
    assign o_rsp.duty_percent     = r_out_duty;
    assign o_rsp.regulator_enable = r_out_en;
    assign o_rsp.drive_up         = r_out_up;
    assign o_rsp.drive_down       = r_out_down;
    assign o_rsp.pwm_level        = r_out_pwm;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("Accepted word produced no result.");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty <= DUTY_MAX)
        else $error("Stored duty exceeds the maximum.");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PHASE_TOP)
        else $error("PWM phase left its period.");

    a_pins_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!(r_out_up && r_out_down) && (r_out_en == (r_out_up || r_out_down))))
        else $error("Motor pin levels disagree.");

    a_tick_no_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.mode) |=> (r_rsp == RSP_NONE))
        else $error("Tick word gave a response code.");

endmodule

// ----- rtl/smcp_decode.sv -----
// Character classifier: sorts a received byte into motor letters, line ends and digits.
// Depends on smcp_pkg.
module smcp_decode (
    input  logic [7:0]            i_byte,
    output smcp_pkg::t_byte_class o_class
);
    import smcp_pkg::*;

    logic [7:0] w_off;

    assign w_off = i_byte - CH_ZERO;

    always_comb begin
        o_class.is_up    = (i_byte == CH_UP_L) || (i_byte == CH_UP_U);
        o_class.is_down  = (i_byte == CH_DN_L) || (i_byte == CH_DN_U);
        o_class.is_stop  = (i_byte == CH_ST_L) || (i_byte == CH_ST_U);
        o_class.is_eol   = (i_byte == CH_CR) || (i_byte == CH_LF);
        o_class.is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        o_class.digit    = w_off[3:0];
    end
endmodule
